[rtl/core/bbox_pkg.sv]
// Shared types, constants and the colour table of the box border overlay.
package bbox_pkg;

  localparam int MAX_BOXES = 16;
  localparam int BOX_IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int BOX_CNT_W = $clog2(MAX_BOXES + 1);

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_PX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [3:0]  BORDER_PX_RESET    = 4'd2;
  localparam logic [12:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [12:0] FRAME_DIM_MAX      = 13'd4096;
  localparam logic [3:0]  PALETTE_LAST       = 4'd9;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PIXEL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_TEST,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [3:0]         pal;
  } box_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic test;
    logic out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pixel;
    logic box_none;
    logic last_box;
    logic out_free;
  } dp_status_t;

  // Entries are {r, g, b}.
  function automatic logic [23:0] palette_rgb(logic [3:0] idx);
    logic [23:0] c;
    case (idx)
      4'd0:    c = {8'd255, 8'd0,   8'd0};
      4'd1:    c = {8'd0,   8'd255, 8'd0};
      4'd2:    c = {8'd0,   8'd0,   8'd255};
      4'd3:    c = {8'd255, 8'd255, 8'd0};
      4'd4:    c = {8'd0,   8'd255, 8'd255};
      4'd5:    c = {8'd255, 8'd0,   8'd255};
      4'd6:    c = {8'd128, 8'd0,   8'd128};
      4'd7:    c = {8'd0,   8'd128, 8'd128};
      4'd8:    c = {8'd128, 8'd128, 8'd0};
      default: c = {8'd0,   8'd0,   8'd128};
    endcase
    return c;
  endfunction

endpackage

[rtl/core/bbox_ctrl.sv]
// Sequencer that steps a pixel word through the stored boxes.
module bbox_ctrl
  import bbox_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output ctl_cmd_t   cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && st.is_pixel) begin
          state_next = st.box_none ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_TEST;
      end
      ST_TEST: begin
        state_next = st.last_box ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = (state != ST_IDLE);
    cmd.capture  = (state == ST_IDLE) && in_valid;
    cmd.test     = (state == ST_TEST);
    cmd.out_load = (state == ST_FINISH) && st.out_free;
  end

  a_read_then_test: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_TEST)
    else $error("box read not followed by its test");

  a_pixel_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && st.is_pixel && !st.box_none) |=> state == ST_READ)
    else $error("pixel word did not start the box scan");

  a_finish_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !st.out_free) |=> (state == ST_FINISH && !cmd.capture))
    else $error("result dropped while the output was busy");

endmodule

[rtl/core/bbox_datapath.sv]
// Box store, configuration registers, border test and output register.
module bbox_datapath
  import bbox_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            op,
  input  logic signed [15:0]    box_left,
  input  logic signed [15:0]    box_top,
  input  logic signed [15:0]    box_right,
  input  logic signed [15:0]    box_bottom,
  input  logic [3:0]            palette_index,
  input  logic [11:0]           pixel_x,
  input  logic [11:0]           pixel_y,
  input  logic [7:0]            in_byte0,
  input  logic [7:0]            in_byte1,
  input  logic [7:0]            in_byte2,
  input  ctl_cmd_t              cmd,
  output dp_status_t            st,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte0,
  output logic [7:0]            out_byte1,
  output logic [7:0]            out_byte2
);

  logic [3:0]  border_px;
  logic [12:0] frame_width;
  logic [12:0] frame_height;

  box_t                 mem [MAX_BOXES];
  box_t                 rd_box;
  logic [BOX_CNT_W-1:0] box_count;
  logic [BOX_IDX_W-1:0] idx;

  logic [11:0] px;
  logic [11:0] py;
  logic [7:0]  work0;
  logic [7:0]  work1;
  logic [7:0]  work2;

  logic [11:0] wm;
  logic [11:0] hm;
  logic        hit;
  logic [23:0] colour;
  logic [3:0]  pal_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      border_px    <= BORDER_PX_RESET;
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BORDER_PX:    border_px    <= cfg_data[3:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pal_sat = (palette_index > PALETTE_LAST) ? PALETTE_LAST : palette_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
    end else if (cmd.capture) begin
      if (op == OP_CLEAR) begin
        box_count <= '0;
      end else if (op == OP_LOAD && box_count < BOX_CNT_W'(MAX_BOXES)) begin
        box_count <= box_count + BOX_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && op == OP_LOAD && box_count < BOX_CNT_W'(MAX_BOXES)) begin
      mem[box_count[BOX_IDX_W-1:0]] <= '{box_left, box_top, box_right, box_bottom, pal_sat};
    end
    rd_box <= mem[idx];
  end

  // Dimensions of zero count as one, anything beyond the largest frame as the largest.
  always_comb begin
    if (frame_width == 13'd0) begin
      wm = 12'd0;
    end else if (frame_width > FRAME_DIM_MAX) begin
      wm = 12'd4095;
    end else begin
      wm = 12'(frame_width - 13'd1);
    end
    if (frame_height == 13'd0) begin
      hm = 12'd0;
    end else if (frame_height > FRAME_DIM_MAX) begin
      hm = 12'd4095;
    end else begin
      hm = 12'(frame_height - 13'd1);
    end
  end

  function automatic logic signed [14:0] clamp_coord(logic signed [15:0] v, logic [11:0] hi);
    logic signed [14:0] r;
    if (v < 16'sd0) begin
      r = 15'sd0;
    end else if (v > $signed({4'b0, hi})) begin
      r = $signed({3'b0, hi});
    end else begin
      r = $signed({3'b0, v[11:0]});
    end
    return r;
  endfunction

  always_comb begin
    logic signed [14:0] l, r, t, b, x, y, lw, wms, hms;
    logic signed [14:0] top_hi, bot_lo, left_hi, right_lo;
    logic               rows, cols;
    wms = $signed({3'b0, wm});
    hms = $signed({3'b0, hm});
    lw  = $signed({11'b0, border_px});
    x   = $signed({3'b0, px});
    y   = $signed({3'b0, py});
    l   = clamp_coord(rd_box.left, wm);
    r   = clamp_coord(rd_box.right, wm);
    t   = clamp_coord(rd_box.top, hm);
    b   = clamp_coord(rd_box.bottom, hm);
    top_hi   = t + lw - 15'sd1;
    bot_lo   = b - lw + 15'sd1;
    left_hi  = l + lw - 15'sd1;
    right_lo = r - lw + 15'sd1;
    if (top_hi > hms)      top_hi = hms;
    if (bot_lo < 15'sd0)   bot_lo = 15'sd0;
    if (left_hi > wms)     left_hi = wms;
    if (right_lo < 15'sd0) right_lo = 15'sd0;
    rows = (x >= l) && (x <= r) &&
           (((y >= t) && (y <= top_hi)) || ((y >= bot_lo) && (y <= b)));
    cols = (y >= t) && (y <= b) &&
           (((x >= l) && (x <= left_hi)) || ((x >= right_lo) && (x <= r)));
    hit = rows || cols;
  end

  assign colour = palette_rgb(rd_box.pal);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.capture) begin
      idx <= '0;
    end else if (cmd.test) begin
      idx <= idx + BOX_IDX_W'(1);
    end
  end

  // Later boxes overwrite earlier ones, so the last hit in load order wins.
  always_ff @(posedge clk) begin
    if (cmd.capture && op == OP_PIXEL) begin
      px    <= pixel_x;
      py    <= pixel_y;
      work0 <= in_byte0;
      work1 <= in_byte1;
      work2 <= in_byte2;
    end else if (cmd.test && hit) begin
      work0 <= colour[7:0];
      work1 <= colour[15:8];
      work2 <= colour[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte0 <= work0;
      out_byte1 <= work1;
      out_byte2 <= work2;
    end
  end

  always_comb begin
    st.is_pixel = (op == OP_PIXEL);
    st.box_none = (box_count == '0);
    st.last_box = ((BOX_CNT_W'(idx) + BOX_CNT_W'(1)) == box_count);
    st.out_free = !out_valid || !out_stall;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    box_count <= BOX_CNT_W'(MAX_BOXES))
    else $error("box count beyond the store depth");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while its word waits");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.test |-> (BOX_CNT_W'(idx) < box_count))
    else $error("box scan past the stored boxes");

endmodule

[rtl/core/bounding_box_border_overlay.sv]
// Top level of the box border overlay: controller and datapath.
//
// Input channel (in_valid / in_stall) carries one word per item: op selects
// clear, load box or pixel. A word is taken when in_valid is high and in_stall
// is low. Clear and load words leave in_stall low and give no output word; a
// load past the last free box slot is ignored. A pixel word yields one output
// word on the out_valid / out_stall channel, carrying the pixel bytes or the
// colour of the last stored box whose border covers the pixel.
// A pixel word is tested against the stored boxes one at a time through the
// single read port of the box store, each box in a read state and then a test
// state; the result is loaded into the output register in the finish state.
// in_stall is high while a pixel is being scanned.
// The output register holds its word while out_stall is high; the block then
// waits at the end of the next pixel until the register is free.
// The configuration port (cfg_write, cfg_index, cfg_data) writes border
// thickness, frame width and frame height. Synchronous reset rst empties the
// box store, restores the register defaults and drops out_valid.
module bounding_box_border_overlay
  import bbox_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            op,
  input  logic signed [15:0]    box_left,
  input  logic signed [15:0]    box_top,
  input  logic signed [15:0]    box_right,
  input  logic signed [15:0]    box_bottom,
  input  logic [3:0]            palette_index,
  input  logic [11:0]           pixel_x,
  input  logic [11:0]           pixel_y,
  input  logic [7:0]            in_byte0,
  input  logic [7:0]            in_byte1,
  input  logic [7:0]            in_byte2,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte0,
  output logic [7:0]            out_byte1,
  output logic [7:0]            out_byte2
);

  ctl_cmd_t   cmd;
  dp_status_t st;

  bbox_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bbox_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .box_left      (box_left),
    .box_top       (box_top),
    .box_right     (box_right),
    .box_bottom    (box_bottom),
    .palette_index (palette_index),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .in_byte0      (in_byte0),
    .in_byte1      (in_byte1),
    .in_byte2      (in_byte2),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte0     (out_byte0),
    .out_byte1     (out_byte1),
    .out_byte2     (out_byte2)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the box border overlay with its own pixel painting predictor.
module testbench;
  import bbox_pkg::*;

  localparam logic [1:0]           OP_SPARE      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
  localparam int                   SETTLE_CYCLES = 2 * MAX_BOXES + 8;
  localparam int                   PHASE_WORDS   = 160;
  localparam int                   LONG_HOLD     = 300;
  localparam int                   PIXEL_MAX     = 4095;

  // Colour entries as {r, g, b}, entry 0 in the lowest bits.
  localparam logic [10*24-1:0] COLOURS = {
    24'h000080, 24'h808000, 24'h008080, 24'h800080, 24'hFF00FF,
    24'h00FFFF, 24'hFFFF00, 24'h0000FF, 24'h00FF00, 24'hFF0000};

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [3:0]         pal;
    logic [11:0]        px;
    logic [11:0]        py;
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
  } overlay_word_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } pixel_bytes_t;

  typedef struct {
    int         left;
    int         top;
    int         right;
    int         bottom;
    logic [3:0] pal;
  } stored_box_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_write     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [1:0]            op            = '0;
  logic signed [15:0]    box_left      = '0;
  logic signed [15:0]    box_top       = '0;
  logic signed [15:0]    box_right     = '0;
  logic signed [15:0]    box_bottom    = '0;
  logic [3:0]            palette_index = '0;
  logic [11:0]           pixel_x       = '0;
  logic [11:0]           pixel_y       = '0;
  logic [7:0]            in_byte0      = '0;
  logic [7:0]            in_byte1      = '0;
  logic [7:0]            in_byte2      = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [7:0]            out_byte0;
  logic [7:0]            out_byte1;
  logic [7:0]            out_byte2;

  // Predictor state: register copies, box store and the pixels still owed.
  logic [3:0]    lw_now = BORDER_PX_RESET;
  logic [12:0]   fw_now = FRAME_WIDTH_RESET;
  logic [12:0]   fh_now = FRAME_HEIGHT_RESET;
  stored_box_t   box_list [MAX_BOXES];
  int            box_total = 0;
  pixel_bytes_t  expected_pixels [$];
  overlay_word_t pending_words [$];
  int            words_queued = 0;
  int            mismatches = 0;
  logic          in_fire = 1'b0;
  int            tx_gap = 0;
  int            tx_burst = 0;
  int            rx_hold = 0;
  int            rx_free = 0;
  int            rx_cycles = 0;

  bounding_box_border_overlay u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .box_left(box_left),
    .box_top(box_top),
    .box_right(box_right),
    .box_bottom(box_bottom),
    .palette_index(palette_index),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .in_byte0(in_byte0),
    .in_byte1(in_byte1),
    .in_byte2(in_byte2),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte0(out_byte0),
    .out_byte1(out_byte1),
    .out_byte2(out_byte2)
  );

  function automatic int frame_extent(logic [12:0] v);
    if (v == 0) return 1;
    if (v > FRAME_DIM_MAX) return int'(FRAME_DIM_MAX);
    return int'(v);
  endfunction

  function automatic int pin(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit on_border(stored_box_t bx, int x, int y);
    int wm, hm, lw, l, r, t, b;
    int top_end, bot_start, left_end, right_start;
    bit rows, cols;
    wm = frame_extent(fw_now) - 1;
    hm = frame_extent(fh_now) - 1;
    lw = int'(lw_now);
    l = pin(bx.left, wm);
    r = pin(bx.right, wm);
    t = pin(bx.top, hm);
    b = pin(bx.bottom, hm);
    top_end = (t + lw - 1 < hm) ? t + lw - 1 : hm;
    bot_start = (b - lw + 1 > 0) ? b - lw + 1 : 0;
    left_end = (l + lw - 1 < wm) ? l + lw - 1 : wm;
    right_start = (r - lw + 1 > 0) ? r - lw + 1 : 0;
    rows = x >= l && x <= r && ((y >= t && y <= top_end) || (y >= bot_start && y <= b));
    cols = y >= t && y <= b && ((x >= l && x <= left_end) || (x >= right_start && x <= r));
    return rows || cols;
  endfunction

  // Later boxes overwrite earlier ones, so the last box that covers the pixel wins.
  function automatic pixel_bytes_t paint_pixel(int x, int y, pixel_bytes_t bytes);
    pixel_bytes_t res;
    logic [23:0] rgb;
    res = bytes;
    for (int i = 0; i < box_total; i++) begin
      if (on_border(box_list[i], x, y)) begin
        rgb = COLOURS[int'(box_list[i].pal) * 24 +: 24];
        res.b0 = rgb[7:0];
        res.b1 = rgb[15:8];
        res.b2 = rgb[23:16];
      end
    end
    return res;
  endfunction

  function automatic int between(int a, int b);
    if (a > b) return b + int'($urandom_range(0, a - b));
    return a + int'($urandom_range(0, b - a));
  endfunction

  function automatic int pick_pause();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic overlay_word_t noise_word();
    overlay_word_t w;
    w.op = 2'($urandom_range(0, 3));
    w.left = 16'($urandom_range(0, 65535));
    w.top = 16'($urandom_range(0, 65535));
    w.right = 16'($urandom_range(0, 65535));
    w.bottom = 16'($urandom_range(0, 65535));
    w.pal = 4'($urandom_range(0, 15));
    w.px = 12'($urandom_range(0, PIXEL_MAX));
    w.py = 12'($urandom_range(0, PIXEL_MAX));
    w.b0 = 8'($urandom_range(0, 255));
    w.b1 = 8'($urandom_range(0, 255));
    w.b2 = 8'($urandom_range(0, 255));
    return w;
  endfunction

  task automatic queue_word(logic [1:0] code);
    overlay_word_t w;
    w = noise_word();
    w.op = code;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_box(int l, int t, int r, int b, int pal);
    overlay_word_t w;
    w = noise_word();
    w.op = OP_LOAD;
    w.left = 16'(l);
    w.top = 16'(t);
    w.right = 16'(r);
    w.bottom = 16'(b);
    w.pal = 4'(pal);
    pending_words.push_back(w);
    words_queued++;
  endtask

  // A negative fill leaves the pixel bytes random.
  task automatic queue_pixel(int x, int y, int fill);
    overlay_word_t w;
    w = noise_word();
    w.op = OP_PIXEL;
    w.px = 12'(pin(x, PIXEL_MAX));
    w.py = 12'(pin(y, PIXEL_MAX));
    if (fill >= 0) begin
      w.b0 = 8'(fill);
      w.b1 = 8'(fill);
      w.b2 = 8'(fill);
    end
    pending_words.push_back(w);
    words_queued++;
  endtask

  // One scene: usually a clear, a handful of boxes, then pixels aimed at their borders.
  task automatic queue_scene(int fw, int fh);
    int n_boxes, n_pixels, r, k, x, y;
    int bl [0:17];
    int bt [0:17];
    int br [0:17];
    int bb [0:17];
    if ($urandom_range(0, 9) != 0) queue_word(OP_CLEAR);
    r = $urandom_range(0, 99);
    if (r < 85) n_boxes = $urandom_range(1, 6);
    else if (r < 95) n_boxes = $urandom_range(7, 15);
    else n_boxes = $urandom_range(16, 18);
    for (int i = 0; i < n_boxes; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        bl[i] = between(-32768, 32767);
        bt[i] = between(-32768, 32767);
        br[i] = between(-32768, 32767);
        bb[i] = between(-32768, 32767);
      end else begin
        bl[i] = between(-8, fw + 8);
        bt[i] = between(-8, fh + 8);
        br[i] = bl[i] + between(-6, 42);
        bb[i] = bt[i] + between(-6, 42);
      end
      queue_box(bl[i], bt[i], br[i], bb[i], $urandom_range(0, 15));
    end
    n_pixels = $urandom_range(3, 12);
    for (int i = 0; i < n_pixels; i++) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, n_boxes - 1);
      if (r < 4) begin
        queue_word(OP_SPARE);
      end else if (r < 20) begin
        queue_pixel($urandom_range(0, PIXEL_MAX), $urandom_range(0, PIXEL_MAX), -1);
      end else if (r < 60) begin
        x = ($urandom_range(0, 1) ? bl[k] : br[k]) + between(-8, 8);
        y = between(bt[k] - 4, bb[k] + 4);
        queue_pixel(x, y, -1);
      end else begin
        x = between(bl[k] - 4, br[k] + 4);
        y = ($urandom_range(0, 1) ? bt[k] : bb[k]) + between(-8, 8);
        queue_pixel(x, y, -1);
      end
    end
  endtask

  // Writes every register, plus the unused index, while the block is idle.
  task automatic write_settings(int lw, int fw, int fh);
    cfg_write <= 1'b1;
    cfg_index <= CFG_BORDER_PX;
    cfg_data <= 13'(($urandom_range(0, 511) << 4) | lw);
    lw_now = 4'(lw);
    @(negedge clk);
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= 13'(fw);
    fw_now = 13'(fw);
    @(negedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data <= 13'(fh);
    fh_now = 13'(fh);
    @(negedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data <= 13'($urandom_range(0, 8191));
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Loads give no output word, so a short wait follows the last pixel word. The
  // driver may take the last word in the same step as the first check, hence the
  // second wait for anything still on its way.
  task automatic settle();
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (in_valid || expected_pixels.size() != 0)
      @(negedge clk);
  endtask

  task automatic compare_byte(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin : driver
    overlay_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        op <= w.op;
        box_left <= w.left;
        box_top <= w.top;
        box_right <= w.right;
        box_bottom <= w.bottom;
        palette_index <= w.pal;
        pixel_x <= w.px;
        pixel_y <= w.py;
        in_byte0 <= w.b0;
        in_byte1 <= w.b1;
        in_byte2 <= w.b2;
        in_valid <= 1'b1;
        if (tx_burst > 0) begin
          tx_burst--;
          tx_gap = 0;
        end else begin
          tx_gap = pick_pause();
          if ($urandom_range(0, 49) == 0) tx_burst = int'($urandom_range(20, 80));
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Periodically the receiver holds off long enough to back the block up; in between it stalls at random.
  always @(negedge clk) begin : receiver
    rx_cycles++;
    if (rx_cycles % 5000 == 2500) rx_hold = LONG_HOLD;
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
      if (rx_free > 0) rx_free--;
      else if ($urandom_range(0, 59) == 0) rx_free = int'($urandom_range(30, 120));
      else if ($urandom_range(0, 3) == 0) rx_hold = pick_pause();
    end
  end

  always @(posedge clk) begin : monitor
    pixel_bytes_t want;
    stored_box_t bx;
    in_fire <= in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("Output word with no pixel outstanding: %0d %0d %0d",
               out_byte0, out_byte1, out_byte2);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        compare_byte("out_byte0", want.b0, out_byte0);
        compare_byte("out_byte1", want.b1, out_byte1);
        compare_byte("out_byte2", want.b2, out_byte2);
      end
    end
    if (!rst && in_valid && !in_stall) begin
      case (op)
        OP_CLEAR: box_total = 0;
        OP_LOAD: begin
          if (box_total < MAX_BOXES) begin
            bx.left = int'(box_left);
            bx.top = int'(box_top);
            bx.right = int'(box_right);
            bx.bottom = int'(box_bottom);
            bx.pal = (palette_index > PALETTE_LAST) ? PALETTE_LAST : palette_index;
            box_list[box_total] = bx;
            box_total++;
          end
        end
        OP_PIXEL: begin
          expected_pixels.push_back(paint_pixel(int'(pixel_x), int'(pixel_y),
                                                {in_byte0, in_byte1, in_byte2}));
        end
        default: ;
      endcase
    end
  end

  initial begin : stimulus
    int target;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings: an empty store, a box reaching far beyond the frame
    // on every side with an out-of-range palette, a box inverted across, two overlapping boxes,
    // a clear and the unused operation.
    queue_pixel(0, 0, 0);
    queue_pixel(PIXEL_MAX, PIXEL_MAX, 255);
    queue_box(-32768, -32768, 32767, 32767, 15);
    queue_pixel(0, 0, -1);
    queue_pixel(639, 479, -1);
    queue_pixel(PIXEL_MAX, PIXEL_MAX, -1);
    queue_pixel(2, 2, -1);
    queue_pixel(1, 300, -1);
    queue_box(100, 50, 40, 200, 3);
    queue_pixel(100, 60, -1);
    queue_pixel(40, 60, -1);
    queue_pixel(70, 50, -1);
    queue_box(5, 5, 30, 30, 1);
    queue_box(20, 5, 40, 30, 4);
    queue_pixel(25, 5, -1);
    queue_word(OP_CLEAR);
    queue_pixel(0, 0, -1);
    queue_word(OP_SPARE);
    queue_pixel(639, 0, -1);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: write_settings(1, 64, 48);
        1: write_settings(10, 4096, 4096);
        2: write_settings(0, 32, 24);
        3: write_settings(15, 0, 8191);
        4: write_settings(3, 1, 1);
        5: write_settings(6, 4097, 2);
        6: write_settings(2, 640, 480);
        default: begin
          write_settings($urandom_range(1, 10), $urandom_range(8, 300),
                         $urandom_range(8, 300));
        end
      endcase
      target = words_queued + PHASE_WORDS;
      while (words_queued < target)
        queue_scene(frame_extent(fw_now), frame_extent(fh_now));
    end

    settle();
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/core/bbox_pkg.sv
rtl/core/bbox_ctrl.sv
rtl/core/bbox_datapath.sv
rtl/core/bounding_box_border_overlay.sv
tb/testbench.sv
